// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TLVEF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("tlvef assertion failed");

// condition must never be true outside reset
`define TLVEF_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("tlvef forbidden condition seen");

`endif

// ----- rtl/tlvef_pkg.sv -----
// types, constants and helpers for the extra-field record finder
`timescale 1ns / 1ps
`default_nettype none

package tlvef_pkg;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 16;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 2 * POS_W;
    localparam int OUT_USER_W = 1;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // register indexes
    localparam logic [0:0] REG_WANTED_ID = 1'b0;

    typedef enum logic [4:0] {
        PH_ID_LO   = 5'b00001,
        PH_ID_HI   = 5'b00010,
        PH_SZ_LO   = 5'b00100,
        PH_SZ_HI   = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        sat_inc = (v == POS_MAX) ? POS_MAX : v + POS_W'(1);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tlv_extra_field_finder_core.sv -----
// extra-field record finder: one byte per item, one result per block
//
//  channel   dir  payload                                   marks
//  s_axis    in   tdata = data_byte, tuser = byte_present   tlast = block_end
//  m_axis    out  tdata = offset, length; tuser = found     (one item per block)
//  apb       in   wanted_id at byte address 0               pready always high
//
// one item is taken per cycle unless the input stalls; the parse state updates in the cycle it is taken
// a result shows in the output register the cycle after the block end item
// the input stalls only while a result waits and m_axis_tready is low
// reset clears the parse state, the output valid flag and wanted_id
`timescale 1ns / 1ps
`default_nettype none

module tlv_extra_field_finder_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // stream in
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [tlvef_pkg::BYTE_W-1:0]     s_axis_tdata,  // [7:0] data_byte
    input  wire  [tlvef_pkg::IN_USER_W-1:0]  s_axis_tuser,  // [0] byte_present
    input  wire                              s_axis_tlast,
    // stream out
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [tlvef_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [15:0] payload_offset, [31:16] payload_length
    output logic [tlvef_pkg::OUT_USER_W-1:0] m_axis_tuser,  // [0] found
    // configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [tlvef_pkg::APB_ADDR_W-1:0] paddr,
    input  wire  [tlvef_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tlvef_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import tlvef_pkg::*;

    logic [POS_W-1:0]  r_wanted_id;
    t_phase            r_phase,       n_phase;
    logic [POS_W-1:0]  r_position,    n_position;
    logic [POS_W-1:0]  r_record_id,   n_record_id;
    logic [POS_W-1:0]  r_record_size, n_record_size;
    logic [POS_W-1:0]  r_payload_left, n_payload_left;
    logic              r_cand,        n_cand;
    logic              r_match_done,  n_match_done;
    logic [POS_W-1:0]  r_match_off,   n_match_off;
    logic [POS_W-1:0]  r_match_len,   n_match_len;

    logic              r_out_valid;
    logic              r_out_found;
    logic [POS_W-1:0]  r_out_off;
    logic [POS_W-1:0]  r_out_len;

    logic              in_take;
    logic              byte_take;
    logic              reg_hit;
    logic [POS_W-1:0]  full_size;

    // configuration port
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1 -: 1] == REG_WANTED_ID);
    assign prdata  = reg_hit ? {{(APB_DATA_W-POS_W){1'b0}}, r_wanted_id} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_id <= '0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_wanted_id <= pwdata[POS_W-1:0];
        end
    end

    // handshake: output register parts the two sides
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign byte_take     = s_axis_tuser[0] && !r_match_done;
    assign full_size     = {s_axis_tdata, r_record_size[BYTE_W-1:0]};

    // parse update for one byte
    always_comb begin
        n_phase        = r_phase;
        n_position     = r_position;
        n_record_id    = r_record_id;
        n_record_size  = r_record_size;
        n_payload_left = r_payload_left;
        n_cand         = r_cand;
        n_match_done   = r_match_done;
        n_match_off    = r_match_off;
        n_match_len    = r_match_len;
        if (byte_take) begin
            n_position = sat_inc(r_position);
            case (r_phase)
                PH_ID_HI: begin
                    n_record_id = {s_axis_tdata, r_record_id[BYTE_W-1:0]};
                    n_phase     = PH_SZ_LO;
                end
                PH_SZ_LO: begin
                    n_record_size = {{(POS_W-BYTE_W){1'b0}}, s_axis_tdata};
                    n_phase       = PH_SZ_HI;
                end
                PH_SZ_HI: begin
                    n_record_size = full_size;
                    if (full_size == '0) begin
                        n_phase = PH_ID_LO;
                    end else begin
                        n_cand = (r_record_id == r_wanted_id);
                        if (r_record_id == r_wanted_id) begin
                            n_match_off = sat_inc(r_position);
                        end
                        n_payload_left = full_size;
                        n_phase        = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_payload_left = r_payload_left - POS_W'(1);
                    if (r_payload_left == POS_W'(1)) begin
                        if (r_cand) begin
                            n_match_done = 1'b1;
                            n_match_len  = r_record_size;
                        end
                        n_cand  = 1'b0;
                        n_phase = PH_ID_LO;
                    end
                end
                default: begin
                    n_record_id = {{(POS_W-BYTE_W){1'b0}}, s_axis_tdata};
                    n_phase     = PH_ID_HI;
                end
            endcase
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_take && s_axis_tlast)) begin
            r_phase        <= PH_ID_LO;
            r_position     <= '0;
            r_record_id    <= '0;
            r_record_size  <= '0;
            r_payload_left <= '0;
            r_cand         <= 1'b0;
            r_match_done   <= 1'b0;
            r_match_off    <= '0;
            r_match_len    <= '0;
        end else if (in_take) begin
            r_phase        <= n_phase;
            r_position     <= n_position;
            r_record_id    <= n_record_id;
            r_record_size  <= n_record_size;
            r_payload_left <= n_payload_left;
            r_cand         <= n_cand;
            r_match_done   <= n_match_done;
            r_match_off    <= n_match_off;
            r_match_len    <= n_match_len;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && s_axis_tlast) begin
            r_out_found <= n_match_done;
            r_out_off   <= n_match_done ? n_match_off : '0;
            r_out_len   <= n_match_done ? n_match_len : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_len, r_out_off};
    assign m_axis_tuser  = r_out_found;

endmodule

`default_nettype wire

// ----- rtl/tlvef_checker.sv -----
// port-level checks for the extra-field record finder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tlvef_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire                              s_axis_tlast,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [tlvef_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input wire [tlvef_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
    import tlvef_pkg::*;

    // a block end item always leaves a result behind
    `TLVEF_ASSERT(a_end_gives_result, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
    // no result waiting means input is open
    `TLVEF_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready)
    // a miss carries zero offset and length
    `TLVEF_NEVER(a_miss_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0] && (m_axis_tdata != '0))
    // a hit always has a nonzero length
    `TLVEF_NEVER(a_hit_len, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] && (m_axis_tdata[OUT_DATA_W-1:POS_W] == '0))
    // stalled result holds
    `TLVEF_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

endmodule

bind tlv_extra_field_finder_core tlvef_checker u_tlvef_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
// self-checking testbench for the extra-field record finder
`timescale 1ns / 1ps

module tb_top;
    import tlvef_pkg::*;

    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int MAX_REPORTS   = 10;

    localparam logic [15:0] ID_IMAGE = 16'h574d;
    localparam logic [15:0] ID_CACHE = 16'h574e;
    localparam logic [15:0] ID_NAME  = 16'h574f;
    localparam logic [15:0] KNOWN_IDS [3] = '{ID_IMAGE, ID_CACHE, ID_NAME};

    localparam logic [APB_ADDR_W-1:0] WANTED_ADDR = APB_ADDR_W'(REG_WANTED_ID) << 2;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } stream_byte_t;

    typedef struct packed {
        logic        found;
        logic [15:0] offset;
        logic [15:0] length;
    } finder_result_t;

    typedef struct packed {
        t_phase      ph;
        logic [15:0] pos;
        logic [15:0] rec_id;
        logic [15:0] rec_size;
        logic [15:0] left;
        logic        cand;
        logic        done;
        logic [15:0] m_off;
        logic [15:0] m_len;
    } finder_state_t;

    // directed row: either a wanted id write or an item, with an optional typed result
    typedef struct packed {
        logic           cfg;
        logic [15:0]    value;
        stream_byte_t   item;
        logic           typed;
        finder_result_t res;
    } plan_row_t;

    localparam finder_state_t FRESH = '{PH_ID_LO, 16'd0, 16'd0, 16'd0, 16'd0,
                                        1'b0, 1'b0, 16'd0, 16'd0};

    localparam plan_row_t PLAN [27] = '{
        // bare end right after reset
        '{1'b0, 16'h0, '{8'h00, 1'b0, 1'b1}, 1'b1, '{1'b0, 16'd0, 16'd0}},
        // zero-size record with the wanted id, then a one-byte match ending with the byte
        '{1'b0, 16'h0, '{8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h01, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'hff, 1'b1, 1'b1}, 1'b1, '{1'b1, 16'd8, 16'd1}},
        // no byte and no end
        '{1'b0, 16'h0, '{8'h5a, 1'b0, 1'b0}, 1'b0, '0},
        '{1'b1, 16'hffff, '0, 1'b0, '0},
        // payload cut short
        '{1'b0, 16'h0, '{8'hff, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'hff, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h03, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h01, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h02, 1'b1, 1'b1}, 1'b1, '{1'b0, 16'd0, 16'd0}},
        // header cut short
        '{1'b0, 16'h0, '{8'hff, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'hff, 1'b1, 1'b1}, 1'b1, '{1'b0, 16'd0, 16'd0}},
        '{1'b1, ID_IMAGE, '0, 1'b0, '0},
        // match, then a byte that must be ignored
        '{1'b0, 16'h0, '{8'h4d, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h57, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h01, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h80, 1'b1, 1'b0}, 1'b0, '0},
        '{1'b0, 16'h0, '{8'h00, 1'b1, 1'b1}, 1'b1, '{1'b1, 16'd4, 16'd1}}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;   // [7:0] data_byte
    logic [IN_USER_W-1:0]  s_axis_tuser;   // [0] byte_present
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [15:0] payload_offset, [31:16] payload_length
    logic [OUT_USER_W-1:0] m_axis_tuser;   // [0] found
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tlv_extra_field_finder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    finder_state_t  parser;
    logic [15:0]    wanted;
    finder_result_t awaited_results [$];
    stream_byte_t   blk [$];
    int             fail_count;
    bit             tx_calm;

    function automatic logic [15:0] bump_pos(input logic [15:0] v);
        return (v == POS_MAX) ? v : v + 16'd1;
    endfunction

    // advances the parser by one item; returns 1 when the item closes a block
    function automatic bit track_byte(input stream_byte_t it, output finder_result_t res);
        res = '0;
        if (it.present && !parser.done) begin
            case (parser.ph)
                PH_ID_HI: begin
                    parser.rec_id[15:8] = it.data;
                    parser.ph = PH_SZ_LO;
                end
                PH_SZ_LO: begin
                    parser.rec_size = {8'h00, it.data};
                    parser.ph = PH_SZ_HI;
                end
                PH_SZ_HI: begin
                    parser.rec_size[15:8] = it.data;
                    if (parser.rec_size == 16'd0) begin
                        parser.ph = PH_ID_LO;
                    end else begin
                        // id compared against the register as it is right now
                        parser.cand = (parser.rec_id == wanted);
                        if (parser.cand)
                            parser.m_off = bump_pos(parser.pos);
                        parser.left = parser.rec_size;
                        parser.ph = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    parser.left = parser.left - 16'd1;
                    if (parser.left == 16'd0) begin
                        if (parser.cand) begin
                            parser.done = 1'b1;
                            parser.m_len = parser.rec_size;
                        end
                        parser.cand = 1'b0;
                        parser.ph = PH_ID_LO;
                    end
                end
                default: begin
                    parser.rec_id = {8'h00, it.data};
                    parser.ph = PH_ID_HI;
                end
            endcase
            parser.pos = bump_pos(parser.pos);
        end
        if (!it.last)
            return 1'b0;
        if (parser.done)
            res = '{1'b1, parser.m_off, parser.m_len};
        parser = FRESH;
        return 1'b1;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch %0d: %s", fail_count, msg);
    endtask

    function automatic int pick_gap();
        int r;
        if (tx_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offers one item, waits for it to be taken, then books its expected result
    task automatic feed_byte(input stream_byte_t it, input bit typed, input finder_result_t res);
        int             gap;
        finder_result_t guess;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.data;
        s_axis_tuser  <= it.present;
        s_axis_tlast  <= it.last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (track_byte(it, guess))
            awaited_results.insert(awaited_results.size(), typed ? res : guess);
    endtask

    task automatic feed_span(input int lo, input int hi);
        for (int k = lo; k < hi; k++)
            feed_byte(blk[k], 1'b0, '0);
    endtask

    // lets all booked results come out and the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_wanted(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WANTED_ADDR;
        pwdata  <= {16'h0000, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        wanted = v;
        // read back right after the write
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== {16'h0000, v})
            note_failure($sformatf("wanted_id read back: expected %h, got %h", v, prdata));
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [15:0] pick_wanted();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hffff;
        if (r < 5)
            return KNOWN_IDS[$urandom_range(0, 2)];
        return 16'($urandom);
    endfunction

    function automatic void put_item(input stream_byte_t it);
        blk.insert(blk.size(), it);
    endfunction

    // occasional no-op items slip in before bytes
    function automatic void add_byte(input logic [7:0] b);
        if ($urandom_range(0, 19) == 0)
            put_item('{8'($urandom), 1'b0, 1'b0});
        put_item('{b, 1'b1, 1'b0});
    endfunction

    function automatic void build_block();
        int          nrec;
        int          roll;
        int          size;
        int          cut;
        logic [15:0] id;
        blk.delete();
        nrec = $urandom_range(0, 4);
        for (int k = 0; k < nrec; k++) begin
            roll = $urandom_range(0, 9);
            if (roll < 4)
                id = wanted;
            else if (roll < 5)
                id = wanted ^ (16'h0001 << $urandom_range(0, 15));
            else if (roll < 7)
                id = KNOWN_IDS[$urandom_range(0, 2)];
            else
                id = 16'($urandom);
            roll = $urandom_range(0, 19);
            if (roll < 2)
                size = 0;
            else if (roll < 17)
                size = $urandom_range(1, 6);
            else
                size = $urandom_range(7, 24);
            add_byte(id[7:0]);
            add_byte(id[15:8]);
            add_byte(size[7:0]);
            add_byte(size[15:8]);
            repeat (size) add_byte(8'($urandom));
        end
        // truncated block: header or payload cut short
        if (blk.size() > 0 && $urandom_range(0, 6) == 0) begin
            cut = $urandom_range(0, blk.size() - 1);
            while (blk.size() > cut) void'(blk.pop_back());
        end
        if (blk.size() > 0 && $urandom_range(0, 1) == 1)
            blk[blk.size() - 1].last = 1'b1;
        else
            put_item('{8'($urandom), 1'b0, 1'b1});
    endfunction

    function automatic int count_live();
        int n;
        n = 0;
        foreach (blk[k])
            if (blk[k].present || blk[k].last)
                n++;
        return n;
    endfunction

    // result checking and receiver side idling
    int rx_cyc;
    int rx_stall;
    int rx_roll;
    finder_result_t rx_got;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_cyc        <= 0;
            rx_stall      <= 0;
        end else begin
            rx_cyc <= rx_cyc + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                rx_got = '{m_axis_tuser[0], m_axis_tdata[15:0], m_axis_tdata[31:16]};
                if (awaited_results.size() == 0) begin
                    note_failure($sformatf("unexpected result found=%0d off=%0d len=%0d",
                                           rx_got.found, rx_got.offset, rx_got.length));
                end else if (rx_got !== awaited_results[0]) begin
                    note_failure($sformatf(
                        "expected found=%0d off=%0d len=%0d, got found=%0d off=%0d len=%0d",
                        awaited_results[0].found, awaited_results[0].offset,
                        awaited_results[0].length, rx_got.found, rx_got.offset,
                        rx_got.length));
                    void'(awaited_results.pop_front());
                end else begin
                    void'(awaited_results.pop_front());
                end
            end
            // long hold-off so the block backs up and stalls its input
            if ((rx_cyc % 1500) >= 1200) begin
                m_axis_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                m_axis_tready <= 1'b0;
                rx_stall      <= rx_stall - 1;
            end else if (rx_cyc[8]) begin
                m_axis_tready <= 1'b1;
            end else begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 25) begin
                    m_axis_tready <= 1'b0;
                    rx_stall <= (rx_roll < 4) ? $urandom_range(10, 40) : $urandom_range(0, 2);
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    int run_cycles = 0;

    always @(posedge i_clk) begin
        run_cycles <= run_cycles + 1;
        if (run_cycles == LIMIT_CYCLES) begin
            $display("** tlv_extra_field_finder_core: FAILED **");
            $finish;
        end
    end

    initial begin
        int          sent;
        int          cfg_left;
        int          split;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        parser     = FRESH;
        wanted     = 16'h0000;
        fail_count = 0;
        tx_calm    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (PLAN[k]) begin
            if (PLAN[k].cfg) begin
                drain();
                write_wanted(PLAN[k].value);
            end else begin
                feed_byte(PLAN[k].item, PLAN[k].typed, PLAN[k].res);
            end
        end

        sent     = 0;
        cfg_left = $urandom_range(80, 200);
        while (sent < RANDOM_ITEMS) begin
            build_block();
            tx_calm = ($urandom_range(0, 4) == 0);
            sent += count_live();
            cfg_left -= blk.size();
            if (cfg_left <= 0) begin
                // the write may land mid-record, so the comparison sees the new id
                split = $urandom_range(0, blk.size());
                feed_span(0, split);
                drain();
                write_wanted(pick_wanted());
                feed_span(split, blk.size());
                cfg_left = $urandom_range(80, 200);
            end else begin
                feed_span(0, blk.size());
            end
        end

        drain();
        if (fail_count == 0)
            $display("** tlv_extra_field_finder_core: PASSED **");
        else
            $display("** tlv_extra_field_finder_core: FAILED **");
        $finish;
    end

endmodule

// ----- tlv_extra_field_finder_core.f -----
+incdir+rtl
rtl/tlvef_pkg.sv
rtl/tlv_extra_field_finder_core.sv
rtl/tlvef_checker.sv
dv/tb_top.sv
